// File: hdl/intel_hex_record_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HEX record parser
// Each macro is compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// a in one cycle requires b in the same cycle
`define IHEX_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ihex assertion failed");
// a in one cycle requires b in the next cycle
`define IHEX_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("ihex assertion failed");
`else
`define IHEX_ASSERT_IMPLIES(label, clk, rst, a, b)
`define IHEX_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// File: hdl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Types and constants shared by the HEX record parser modules.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_WAIT  = 6'b000001,
    PH_COUNT = 6'b000010,
    PH_ADDR  = 6'b000100,
    PH_TYPE  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHK   = 6'b100000
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [3:0] BAD_NIBBLE = 4'hF;
  localparam logic [7:0] BAD_BYTE   = 8'hFF;
  localparam logic [3:0] NIBBLE_A   = 4'hA;

  // decoded hex digit
  typedef struct packed {
    logic [3:0] value;
    logic       ok;
  } nib_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] record_number;
    logic [7:0]  byte_count;
    logic [15:0] load_address;
    logic [7:0]  record_type;
    logic [7:0]  data_index;
    logic [7:0]  byte_value;
  } res_t;

endpackage

// File: hdl/ihex_nibble.sv
// ----------------------------------------------------------------------------
// ihex_nibble
// Decodes one ASCII character as a hex digit; anything else gives 0xF.
// ----------------------------------------------------------------------------
module ihex_nibble
  import ihex_pkg::*;
(
  input  logic [7:0] char_in,
  output nib_t       nib
);

  // ranges 0-9, a-f, A-F
  always_comb begin
    nib.ok    = 1'b1;
    nib.value = BAD_NIBBLE;
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      nib.value = char_in[3:0];
    end else if ((char_in >= 8'h61 && char_in <= 8'h66) ||
                 (char_in >= 8'h41 && char_in <= 8'h46)) begin
      // low three bits run 1..6 for a..f and A..F
      nib.value = NIBBLE_A + 4'(char_in[2:0] - 3'd1);
    end else begin
      nib.ok = 1'b0;
    end
  end

endmodule

// File: hdl/ihex_fsm.sv
// ----------------------------------------------------------------------------
// ihex_fsm
// Record state machine: walks the fields of a record one character per step
// and builds the header, data and checksum results.
// ----------------------------------------------------------------------------
module ihex_fsm
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_in,
  output logic       emit,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [1:0]  digit_pos, digit_pos_next;
  logic [15:0] partial_value, partial_value_next;
  logic [7:0]  count_reg, count_reg_next;
  logic [15:0] address_reg, address_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  index_reg, index_reg_next;
  logic [15:0] record_counter, record_counter_next;

  nib_t        nib;
  logic [7:0]  byte_val;

  ihex_nibble u_nibble (
    .char_in (char_in),
    .nib     (nib)
  );

  // completed byte on the second digit; a bad low digit spoils the byte
  assign byte_val = nib.ok ? {partial_value[3:0], nib.value} : BAD_BYTE;

  // next state and result
  always_comb begin
    phase_next          = phase;
    digit_pos_next      = digit_pos;
    partial_value_next  = partial_value;
    count_reg_next      = count_reg;
    address_reg_next    = address_reg;
    type_reg_next       = type_reg;
    index_reg_next      = index_reg;
    record_counter_next = record_counter;
    emit                = 1'b0;
    res.kind            = KIND_HEADER;
    res.record_number   = record_counter;
    res.byte_count      = count_reg;
    res.load_address    = address_reg;
    res.record_type     = type_reg;
    res.data_index      = 8'd0;
    res.byte_value      = 8'd0;

    unique case (phase)
      PH_COUNT: begin
        if (digit_pos == 2'd0) begin
          partial_value_next = {12'd0, nib.value};
          digit_pos_next     = 2'd1;
        end else begin
          digit_pos_next     = 2'd0;
          count_reg_next     = byte_val;
          partial_value_next = 16'd0;
          phase_next         = PH_ADDR;
        end
      end
      PH_ADDR: begin
        partial_value_next = {partial_value[11:0], nib.value};
        if (digit_pos == 2'd3) begin
          address_reg_next = partial_value_next;
          digit_pos_next   = 2'd0;
          phase_next       = PH_TYPE;
        end else begin
          digit_pos_next = digit_pos + 2'd1;
        end
      end
      PH_TYPE: begin
        if (digit_pos == 2'd0) begin
          partial_value_next = {12'd0, nib.value};
          digit_pos_next     = 2'd1;
        end else begin
          digit_pos_next  = 2'd0;
          type_reg_next   = byte_val;
          index_reg_next  = 8'd0;
          phase_next      = (byte_val == TYPE_DATA && count_reg != 8'd0) ? PH_DATA : PH_CHK;
          emit            = 1'b1;
          res.record_type = byte_val;
        end
      end
      PH_DATA: begin
        if (digit_pos == 2'd0) begin
          partial_value_next = {12'd0, nib.value};
          digit_pos_next     = 2'd1;
        end else begin
          digit_pos_next = 2'd0;
          emit           = 1'b1;
          res.kind       = KIND_DATA;
          res.data_index = index_reg;
          res.byte_value = byte_val;
          index_reg_next = index_reg + 8'd1;
          if (index_reg_next >= count_reg) begin
            phase_next = PH_CHK;
          end
        end
      end
      PH_CHK: begin
        if (digit_pos == 2'd0) begin
          partial_value_next = {12'd0, nib.value};
          digit_pos_next     = 2'd1;
        end else begin
          digit_pos_next = 2'd0;
          phase_next     = PH_WAIT;
          emit           = 1'b1;
          res.kind       = KIND_CHECK;
          res.byte_value = byte_val;
        end
      end
      default: begin
        // waiting for a colon
        phase_next = PH_WAIT;
        if (char_in == CHAR_COLON) begin
          record_counter_next = record_counter + 16'd1;
          digit_pos_next      = 2'd0;
          partial_value_next  = 16'd0;
          phase_next          = PH_COUNT;
        end
      end
    endcase
  end

  // state registers, advanced once per character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      digit_pos      <= 2'd0;
      partial_value  <= 16'd0;
      count_reg      <= 8'd0;
      address_reg    <= 16'd0;
      type_reg       <= 8'd0;
      index_reg      <= 8'd0;
      record_counter <= 16'd0;
    end else if (step) begin
      phase          <= phase_next;
      digit_pos      <= digit_pos_next;
      partial_value  <= partial_value_next;
      count_reg      <= count_reg_next;
      address_reg    <= address_reg_next;
      type_reg       <= type_reg_next;
      index_reg      <= index_reg_next;
      record_counter <= record_counter_next;
    end
  end

endmodule

// File: hdl/ihex_outreg.sv
// ----------------------------------------------------------------------------
// ihex_outreg
// Result register with valid/ready handshake towards the consumer.
// ----------------------------------------------------------------------------
module ihex_outreg
  import ihex_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic emit,
  input  res_t res_in,
  input  logic out_ready,
  output logic out_valid,
  output logic stall,
  output res_t res_out
);

  // a held result blocks the parser until it is taken
  assign stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && emit) begin
      res_out <= res_in;
    end
  end

endmodule

// File: hdl/intel_hex_record_parser.sv
// A character accepted into the character register is parsed when it steps
// the record state machine, and its result, if any, is loaded into the result
// register and raised on out_valid. Throughput: one character per cycle, through
// the record state machine between the character register and the result register;
// the input stalls only while a result waits to be taken.
// Reset (rst, synchronous): waiting for a colon, all fields and counters zero.
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Streaming HEX record parser: one ASCII character in per item, header, data
// byte and checksum results out.
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_assert.svh"

module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] record_number,
  output logic [7:0]  byte_count,
  output logic [15:0] load_address,
  output logic [7:0]  record_type,
  output logic [7:0]  data_index,
  output logic [7:0]  byte_value
);

  logic       char_vld;
  logic [7:0] char_reg;
  logic       stall;
  logic       step;
  logic       emit;
  res_t       res_next;
  res_t       res;

  // the held character moves on unless a result is stuck at the output
  assign step     = char_vld && !stall;
  assign in_ready = !char_vld || step;

  // input character register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_vld <= 1'b0;
    end else if (in_ready) begin
      char_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_reg <= char_in;
    end
  end

  ihex_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .char_in (char_reg),
    .emit    (emit),
    .res     (res_next)
  );

  ihex_outreg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .emit      (emit),
    .res_in    (res_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stall     (stall),
    .res_out   (res)
  );

  assign kind          = res.kind;
  assign record_number = res.record_number;
  assign byte_count    = res.byte_count;
  assign load_address  = res.load_address;
  assign record_type   = res.record_type;
  assign data_index    = res.data_index;
  assign byte_value    = res.byte_value;

  // checks
  `IHEX_ASSERT_IMPLIES(a_data_in_range, clk, rst, out_valid && kind == KIND_DATA,
                       data_index < byte_count)
  `IHEX_ASSERT_IMPLIES(a_header_zero, clk, rst, out_valid && kind == KIND_HEADER,
                       data_index == 8'd0 && byte_value == 8'd0)
  `IHEX_ASSERT_IMPLIES(a_kind_legal, clk, rst, out_valid,
                       kind == KIND_HEADER || kind == KIND_DATA || kind == KIND_CHECK)
  `IHEX_ASSERT_NEXT(a_stall_holds_char, clk, rst, char_vld && stall, char_vld && $stable(char_reg))

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for intel_hex_record_parser
// Streams ASCII characters into the parser and checks every header, data
// byte and checksum result against a cycle-free model of the record parser.
// ----------------------------------------------------------------------------
module tb
  import ihex_pkg::*;
();

  localparam logic [7:0] TYPE_EOF = 8'h01;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] record_number;
  logic [7:0]  byte_count;
  logic [15:0] load_address;
  logic [7:0]  record_type;
  logic [7:0]  data_index;
  logic [7:0]  byte_value;

  // stall controls, in percent of cycles
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bad_digit_pct = 0;
  int hold_cycles = 0;
  int error_count = 0;
  int record_chars = 0;

  // parser model state
  phase_t      ph;
  logic [1:0]  dig_pos;
  logic [15:0] acc;
  logic [7:0]  cnt_q;
  logic [15:0] addr_q;
  logic [7:0]  type_q;
  logic [7:0]  idx_q;
  logic [15:0] rec_count;

  res_t        pending_results[$];
  logic [7:0]  record_text[$];

  intel_hex_record_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .record_number(record_number),
    .byte_count   (byte_count),
    .load_address (load_address),
    .record_type  (record_type),
    .data_index   (data_index),
    .byte_value   (byte_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Model of the parser
  // ------------------------------------------------------------------

  function automatic logic [3:0] nibble_of(input logic [7:0] c, output logic ok);
    ok = 1'b1;
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + NIBBLE_A);
    if (c >= "A" && c <= "F") return 4'(c - "A" + NIBBLE_A);
    ok = 1'b0;
    return BAD_NIBBLE;
  endfunction

  // two-digit byte assembly; true once the low digit is in
  function automatic logic assemble_byte(input logic [3:0] n, input logic ok,
                                         output logic [7:0] v);
    v = 8'h00;
    if (dig_pos == 2'd0) begin
      acc = {12'h000, n};
      dig_pos = 2'd1;
      return 1'b0;
    end
    dig_pos = 2'd0;
    v = ok ? {acc[3:0], n} : BAD_BYTE;
    return 1'b1;
  endfunction

  function automatic void queue_result(input logic [1:0] k, input logic [7:0] idx,
                                       input logic [7:0] val);
    res_t r;
    r.kind          = k;
    r.record_number = rec_count;
    r.byte_count    = cnt_q;
    r.load_address  = addr_q;
    r.record_type   = type_q;
    r.data_index    = idx;
    r.byte_value    = val;
    pending_results.push_back(r);
  endfunction

  task automatic parse_char(input logic [7:0] c);
    logic       ok;
    logic [3:0] n;
    logic [7:0] v;
    n = nibble_of(c, ok);
    case (ph)
      PH_COUNT: begin
        if (assemble_byte(n, ok, v)) begin
          cnt_q = v;
          acc   = 16'h0000;
          ph    = PH_ADDR;
        end
      end
      PH_ADDR: begin
        acc = {acc[11:0], n};
        if (dig_pos == 2'd3) begin
          addr_q  = acc;
          dig_pos = 2'd0;
          ph      = PH_TYPE;
        end else begin
          dig_pos = dig_pos + 2'd1;
        end
      end
      PH_TYPE: begin
        if (assemble_byte(n, ok, v)) begin
          type_q = v;
          idx_q  = 8'h00;
          ph     = (type_q == TYPE_DATA && cnt_q != 8'h00) ? PH_DATA : PH_CHK;
          queue_result(KIND_HEADER, 8'h00, 8'h00);
        end
      end
      PH_DATA: begin
        if (assemble_byte(n, ok, v)) begin
          queue_result(KIND_DATA, idx_q, v);
          idx_q = idx_q + 8'h01;
          if (idx_q >= cnt_q) ph = PH_CHK;
        end
      end
      PH_CHK: begin
        if (assemble_byte(n, ok, v)) begin
          ph = PH_WAIT;
          queue_result(KIND_CHECK, 8'h00, v);
        end
      end
      default: begin
        // outside a record only a colon matters
        ph = PH_WAIT;
        if (c == CHAR_COLON) begin
          rec_count = rec_count + 16'h0001;
          dig_pos   = 2'd0;
          acc       = 16'h0000;
          ph        = PH_COUNT;
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // result checker and model update, both on the sampled edge
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      ph        = PH_WAIT;
      dig_pos   = 2'd0;
      acc       = 16'h0000;
      cnt_q     = 8'h00;
      addr_q    = 16'h0000;
      type_q    = 8'h00;
      idx_q     = 8'h00;
      rec_count = 16'h0000;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result of kind %0d with nothing pending", kind));
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", 16'(kind), 16'(want.kind));
          compare_field("record_number", record_number, want.record_number);
          compare_field("byte_count", 16'(byte_count), 16'(want.byte_count));
          compare_field("load_address", load_address, want.load_address);
          compare_field("record_type", 16'(record_type), 16'(want.record_type));
          compare_field("data_index", 16'(data_index), 16'(want.data_index));
          compare_field("byte_value", 16'(byte_value), 16'(want.byte_value));
        end
      end
      if (in_valid && in_ready) parse_char(char_in);
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // one item; returns at the edge where it is taken, valid left high
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // stop offering and let every pending result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // feed zeros until the model sits outside a record again
  task automatic resync_parser();
    while (ph != PH_WAIT) begin
      send_char("0");
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < NIBBLE_A) return "0" + n;
    return (upper ? "A" : "a") + n - NIBBLE_A;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    logic [7:0] c;
    logic       ok;
    if ($urandom_range(99) < bad_digit_pct) begin
      do begin
        c = 8'($urandom_range(255));
        void'(nibble_of(c, ok));
      end while (ok);
      return c;
    end
    return hex_char(n, 1'($urandom_range(1)));
  endfunction

  function automatic void add_hex_byte(input logic [7:0] b);
    record_text.push_back(digit_char(b[7:4]));
    record_text.push_back(digit_char(b[3:0]));
  endfunction

  // well-formed record text with random payload and checksum
  function automatic void build_record(input logic [7:0] cnt, input logic [15:0] addr,
                                       input logic [7:0] rtype);
    record_text.delete();
    record_text.push_back(CHAR_COLON);
    add_hex_byte(cnt);
    add_hex_byte(addr[15:8]);
    add_hex_byte(addr[7:0]);
    add_hex_byte(rtype);
    if (rtype == TYPE_DATA)
      repeat (cnt) add_hex_byte(8'($urandom_range(255)));
    add_hex_byte(8'($urandom_range(255)));
  endfunction

  task automatic send_record_text(input int len);
    for (int i = 0; i < len; i++) send_char(record_text[i]);
    record_chars += len;
  endtask

  task automatic send_random_record();
    int         roll;
    int         len;
    logic [7:0] cnt;
    logic [7:0] rtype;
    roll = $urandom_range(99);
    // line noise between records
    if (roll < 10) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)));
      return;
    end
    cnt  = 8'(($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6));
    roll = $urandom_range(99);
    if (roll < 70)      rtype = TYPE_DATA;
    else if (roll < 85) rtype = TYPE_EOF;
    else                rtype = 8'($urandom_range(255));
    build_record(cnt, 16'($urandom_range(65535)), rtype);
    // a few records are cut short and run into the next
    len = record_text.size();
    if ($urandom_range(99) < 6) len = $urandom_range(1, len - 1);
    send_record_text(len);
    if ($urandom_range(1)) begin
      send_char(CHAR_CR);
      send_char(CHAR_LF);
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // data record at the top address: zero and all-ones bytes, a colon as a
  // low digit, and an invalid high checksum digit
  task automatic test_data_record();
    send_text("x:03FFFF00");
    send_text("00fF9:zA");
  endtask

  // empty data record, then a non-data record whose count is ignored
  task automatic test_empty_records();
    send_text(":0000000000");
    send_text(":05123401FF");
    send_char(CHAR_LF);
  endtask

  task automatic test_random_records(input int n_items);
    int goal;
    goal = record_chars + n_items;
    bad_digit_pct = 4;
    while (record_chars < goal) send_random_record();
    bad_digit_pct = 0;
  endtask

  // long data record while the receiver holds off, so the parser backs up
  task automatic test_backpressure();
    wait_idle();
    resync_parser();
    build_record(8'h40, 16'($urandom_range(65535)), TYPE_DATA);
    hold_cycles = 400;
    send_record_text(record_text.size());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 18;
    rx_idle_pct = 56;
    test_data_record();
    test_empty_records();
    test_random_records(275);
    wait_idle();

    tx_idle_pct = 56;
    rx_idle_pct = 18;
    test_random_records(275);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("intel_hex_record_parser: match");
    end else begin
      $display("intel_hex_record_parser: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("intel_hex_record_parser: mismatch");
    $finish;
  end

endmodule
